>>> design/life_generation_row_engine_macros.svh
// Assertion macros for the Life row engine.
// Used by lgre_out_fifo and life_generation_row_engine; no other dependencies.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef LIFE_GENERATION_ROW_ENGINE_MACROS_SVH
`define LIFE_GENERATION_ROW_ENGINE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define LGRE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define LGRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LGRE_ASSERT_NOW(label, ante, cons, msg)
`define LGRE_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> design/lgre_pkg.sv
// Shared types and constants for the Life row engine.
// No dependencies; used by lgre_cell, lgre_out_fifo and the top level.
`timescale 1ns / 1ps

package lgre_pkg;

	localparam int ROW_BITS      = 64;
	localparam int CFG_BITS      = 7;
	localparam int WIDTH_RESET   = 64;
	localparam int FIFO_DEPTH    = 4;
	localparam int FIFO_PTR_BITS = 2;
	localparam int FIFO_CNT_BITS = 3;

	typedef logic [ROW_BITS-1:0]      lgre_row_t;
	typedef logic [CFG_BITS-1:0]      lgre_width_t;
	typedef logic [FIFO_PTR_BITS-1:0] lgre_ptr_t;
	typedef logic [FIFO_CNT_BITS-1:0] lgre_cnt_t;

	// one column's bits as seen by its neighbors
	typedef struct packed {
		logic older;
		logic middle;
		logic cur;
	} lgre_col_t;

	// one result row
	typedef struct packed {
		lgre_row_t cells;
		logic      fin;
	} lgre_result_t;

	// up to two results written per transfer, second only with first
	typedef struct packed {
		logic         v0;
		lgre_result_t d0;
		logic         v1;
		lgre_result_t d1;
	} lgre_push_t;

endpackage

>>> design/lgre_cell.sv
// One column cell: holds the older and middle row bits of its column and
// evaluates B3/S23 for both possible result rows. Depends on lgre_pkg.
`timescale 1ns / 1ps

module lgre_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              live,
	input  logic              cur_raw,
	input  logic              load,
	input  logic              clear,
	input  lgre_pkg::lgre_col_t left,
	input  lgre_pkg::lgre_col_t right,
	output lgre_pkg::lgre_col_t col,
	output logic              next_a,
	output logic              next_b
);

	logic       older_q;
	logic       middle_q;
	logic       cur;
	logic [3:0] n_a;
	logic [3:0] n_b;

	// born on three, survive on two or three
	function automatic logic life_rule(input logic [3:0] n, input logic alive);
		life_rule = (n == 4'd3) || ((n == 4'd2) && alive);
	endfunction

	assign cur = cur_raw & live;

	assign col.older  = older_q;
	assign col.middle = middle_q;
	assign col.cur    = cur;

	// result A: middle row between older (above) and incoming (below)
	assign n_a = 4'(left.older) + 4'(left.middle) + 4'(left.cur)
		+ 4'(right.older) + 4'(right.middle) + 4'(right.cur)
		+ 4'(older_q) + 4'(cur);

	// result B: incoming row between middle (above) and dead space (below)
	assign n_b = 4'(left.middle) + 4'(left.cur)
		+ 4'(right.middle) + 4'(right.cur) + 4'(middle_q);

	assign next_a = life_rule(n_a, middle_q) & live;
	assign next_b = life_rule(n_b, cur) & live;

	// row window shift; end of grid returns to all dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_q  <= 1'b0;
			middle_q <= 1'b0;
		end else if (load) begin
			if (clear) begin
				older_q  <= 1'b0;
				middle_q <= 1'b0;
			end else begin
				older_q  <= middle_q;
				middle_q <= cur;
			end
		end
	end

endmodule

>>> design/lgre_out_fifo.sv
// Four-entry result queue, two writes and one read per cycle.
// Depends on lgre_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "life_generation_row_engine_macros.svh"

module lgre_out_fifo (
	input  logic                   clk,
	input  logic                   arst_n,
	input  lgre_pkg::lgre_push_t   push,
	input  logic                   pop,
	output logic                   room2,
	output logic                   head_valid,
	output lgre_pkg::lgre_result_t head_data
);

	lgre_pkg::lgre_result_t mem_q [lgre_pkg::FIFO_DEPTH];
	lgre_pkg::lgre_ptr_t    wr_q;
	lgre_pkg::lgre_ptr_t    rd_q;
	lgre_pkg::lgre_cnt_t    cnt_q;
	logic [1:0]             push_n;

	assign push_n     = {1'b0, push.v0} + {1'b0, push.v1};
	assign room2      = cnt_q <= lgre_pkg::lgre_cnt_t'(lgre_pkg::FIFO_DEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head_data  = mem_q[rd_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_q] <= push.d0;
		end
		if (push.v1) begin
			mem_q[wr_q + lgre_pkg::lgre_ptr_t'(1)] <= push.d1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + lgre_pkg::lgre_ptr_t'(push_n);
			rd_q  <= rd_q + lgre_pkg::lgre_ptr_t'(pop);
			cnt_q <= cnt_q + lgre_pkg::lgre_cnt_t'(push_n) - lgre_pkg::lgre_cnt_t'(pop);
		end
	end

	`LGRE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= lgre_pkg::lgre_cnt_t'(lgre_pkg::FIFO_DEPTH), "fifo count overflow")
	`LGRE_ASSERT_NOW(a_push_room, push.v0, room2, "write without room for two entries")
	`LGRE_ASSERT_NOW(a_pair_order, push.v1, push.v0, "second write without first")
	`LGRE_ASSERT_NEXT(a_drain, pop && !push.v0, cnt_q == $past(cnt_q) - lgre_pkg::lgre_cnt_t'(1), "count did not drop on read")

endmodule

>>> design/life_generation_row_engine.sv
// A result is written into the result queue when its row transfers and is offered from the queue head.
// One row per cycle unless stalled; a last row after a held row gives two results, read one per cycle unless stalled.
// The four-entry result queue stalls input when fewer than two entries are free.
// Reset clears the held rows, the queue and sets active_width to 64.
// Holds one lgre_cell per column and the lgre_out_fifo; depends on lgre_pkg.
`timescale 1ns / 1ps
`include "life_generation_row_engine_macros.svh"

module life_generation_row_engine #(
	parameter int MAX_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lgre_pkg::CFG_BITS-1:0] cfg_wdata,
	input  logic                        row_valid,
	output logic                        row_stall,
	input  logic [lgre_pkg::ROW_BITS-1:0] row_cells,
	input  logic                        last_row,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [lgre_pkg::ROW_BITS-1:0] next_row_cells,
	output logic                        final_result
);

	lgre_pkg::lgre_width_t  active_width_q;
	logic                   has_row_q;
	logic                   accept;
	logic                   room2;
	logic                   pop;
	logic [MAX_WIDTH-1:0]   live;
	logic [MAX_WIDTH-1:0]   next_a;
	logic [MAX_WIDTH-1:0]   next_b;
	logic [MAX_WIDTH-1:0]   held_vec;
	lgre_pkg::lgre_row_t    row_a;
	lgre_pkg::lgre_row_t    row_b;
	lgre_pkg::lgre_col_t    cols      [MAX_WIDTH];
	lgre_pkg::lgre_col_t    left_col  [MAX_WIDTH];
	lgre_pkg::lgre_col_t    right_col [MAX_WIDTH];
	lgre_pkg::lgre_push_t   push;
	lgre_pkg::lgre_result_t head;

	assign accept    = row_valid && !row_stall;
	assign row_stall = !room2;
	assign pop       = result_valid && !result_stall;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= lgre_pkg::lgre_width_t'(lgre_pkg::WIDTH_RESET);
		end else if (cfg_we) begin
			active_width_q <= cfg_wdata;
		end
	end

	// a row is held once one non-last row has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_row_q <= 1'b0;
		end else if (accept) begin
			has_row_q <= !last_row;
		end
	end

	// column chain; outside columns read as dead
	genvar k;
	generate
		for (k = 0; k < MAX_WIDTH; k++) begin : g_col
			assign live[k]     = active_width_q > lgre_pkg::lgre_width_t'(k);
			assign held_vec[k] = cols[k].older | cols[k].middle;
			if (k == 0) begin : g_lo
				assign left_col[k] = '0;
			end else begin : g_lo
				assign left_col[k] = cols[k-1];
			end
			if (k == MAX_WIDTH - 1) begin : g_hi
				assign right_col[k] = '0;
			end else begin : g_hi
				assign right_col[k] = cols[k+1];
			end
			lgre_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.live    (live[k]),
				.cur_raw (row_cells[k]),
				.load    (accept),
				.clear   (last_row),
				.left    (left_col[k]),
				.right   (right_col[k]),
				.col     (cols[k]),
				.next_a  (next_a[k]),
				.next_b  (next_b[k])
			);
		end
	endgenerate

	assign row_a = lgre_pkg::lgre_row_t'(next_a);
	assign row_b = lgre_pkg::lgre_row_t'(next_b);

	// results of this transfer: middle row if one is held, then last row
	always_comb begin
		push.v0       = accept && (has_row_q || last_row);
		push.d0.cells = has_row_q ? row_a : row_b;
		push.d0.fin   = !has_row_q;
		push.v1       = accept && has_row_q && last_row;
		push.d1.cells = row_b;
		push.d1.fin   = 1'b1;
	end

	lgre_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room2      (room2),
		.head_valid (result_valid),
		.head_data  (head)
	);

	assign next_row_cells = head.cells;
	assign final_result   = head.fin;

	`LGRE_ASSERT_NEXT(a_last_clears, accept && last_row, !has_row_q, "row held after last row")
	`LGRE_ASSERT_NEXT(a_row_held, accept && !last_row, has_row_q, "row not held after transfer")
	`LGRE_ASSERT_NOW(a_empty_window, !has_row_q, held_vec == '0, "cells hold data with no row held")

endmodule

>>> sim/life_generation_row_engine_test.sv
// Self-checking testbench for life_generation_row_engine: streams Life grids row by row
// and compares every result row against an in-bench generation predictor.
// Depends on lgre_pkg and the life_generation_row_engine RTL only.
`timescale 1ns / 1ps

module life_generation_row_engine_test;

	localparam int MAX_COLS       = 64;
	localparam int HOLD_CYCLES    = 60;
	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ROWS     = 150;
	localparam int PHASE_COUNT    = 12;

	typedef struct {
		lgre_pkg::lgre_row_t cells;
		logic                last;
	} grid_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	lgre_pkg::lgre_width_t cfg_wdata = '0;
	logic                  row_valid = 1'b0;
	logic                  row_stall;
	lgre_pkg::lgre_row_t   row_cells = '0;
	logic                  last_row = 1'b0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	lgre_pkg::lgre_row_t   next_row_cells;
	logic                  final_result;

	life_generation_row_engine dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.row_valid     (row_valid),
		.row_stall     (row_stall),
		.row_cells     (row_cells),
		.last_row      (last_row),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.next_row_cells(next_row_cells),
		.final_result  (final_result)
	);

	// rows waiting to be offered, and result rows still owed by the block
	grid_row_t              row_backlog[$];
	lgre_pkg::lgre_result_t expected_rows[$];

	// predictor state
	lgre_pkg::lgre_width_t  grid_width = lgre_pkg::lgre_width_t'(lgre_pkg::WIDTH_RESET);
	lgre_pkg::lgre_row_t    row_above = '0;
	lgre_pkg::lgre_row_t    row_mid = '0;
	int                     rows_held = 0;

	// idling knobs, percent of cycles
	int             send_idle_pct = 0;
	int             recv_stall_pct = 0;
	int             hold_requests = 0;
	int             holds_served = 0;
	int             hold_left = 0;

	logic           row_took = 1'b0;
	int             quiet_cycles = 0;
	int             fault_count = 0;
	int             rows_sent = 0;
	int             results_seen = 0;
	int             grids_sent = 0;
	int             width_writes = 0;
	int             grid_rows_left = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// live columns for a given width setting
	function automatic lgre_pkg::lgre_row_t column_span(lgre_pkg::lgre_width_t w);
		int n;
		n = (int'(w) > MAX_COLS) ? MAX_COLS : int'(w);
		if (n >= lgre_pkg::ROW_BITS)
			return '1;
		return (lgre_pkg::lgre_row_t'(1) << n) - lgre_pkg::lgre_row_t'(1);
	endfunction

	// B3/S23 applied to the middle row of a 3-row window
	function automatic lgre_pkg::lgre_row_t life_rule_row(lgre_pkg::lgre_row_t above,
			lgre_pkg::lgre_row_t mid, lgre_pkg::lgre_row_t below,
			lgre_pkg::lgre_row_t span);
		lgre_pkg::lgre_row_t nxt;
		int                  n;
		int                  j;
		nxt = '0;
		for (int k = 0; k < lgre_pkg::ROW_BITS; k++) begin
			n = 0;
			for (int d = -1; d <= 1; d++) begin
				j = k + d;
				if (j >= 0 && j < lgre_pkg::ROW_BITS) begin
					n += int'(above[j]) + int'(below[j]);
					if (d != 0)
						n += int'(mid[j]);
				end
			end
			nxt[k] = (n == 3) || (n == 2 && mid[k]);
		end
		return nxt & span;
	endfunction

	function automatic lgre_pkg::lgre_result_t make_result(lgre_pkg::lgre_row_t cells,
			logic fin);
		lgre_pkg::lgre_result_t r;
		r.cells = cells;
		r.fin = fin;
		return r;
	endfunction

	// fold one accepted row into the predictor
	task automatic advance_generation(lgre_pkg::lgre_row_t cells, logic last);
		lgre_pkg::lgre_row_t span;
		lgre_pkg::lgre_row_t cur;
		span = column_span(grid_width);
		cur = cells & span;
		if (last)
			grids_sent++;
		if (rows_held == 0) begin
			if (last) begin
				expected_rows.push_back(make_result(life_rule_row('0, cur, '0, span), 1'b1));
			end else begin
				row_above = '0;
				row_mid = cur;
				rows_held = 1;
			end
		end else begin
			expected_rows.push_back(make_result(life_rule_row(row_above, row_mid, cur, span),
				1'b0));
			if (last) begin
				expected_rows.push_back(make_result(life_rule_row(row_mid, cur, '0, span), 1'b1));
				row_above = '0;
				row_mid = '0;
				rows_held = 0;
			end else begin
				row_above = row_mid;
				row_mid = cur;
				rows_held = 2;
			end
		end
	endtask

	task automatic log_fault(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	// monitor: result check, prediction, watchdog
	always @(posedge clk) begin
		lgre_pkg::lgre_result_t want;
		row_took <= arst_n && row_valid && !row_stall;
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (expected_rows.size() == 0) begin
				log_fault($sformatf("unexpected result: cells %h fin %b",
					next_row_cells, final_result));
			end else begin
				want = expected_rows.pop_front();
				if (want.cells !== next_row_cells || want.fin !== final_result)
					log_fault($sformatf("mismatch: expected cells %h fin %b, got cells %h fin %b",
						want.cells, want.fin, next_row_cells, final_result));
			end
		end
		if (arst_n && row_valid && !row_stall) begin
			rows_sent++;
			advance_generation(row_cells, last_row);
		end
		// watchdog on cycles without any transfer
		if (!arst_n || (row_valid && !row_stall) || (result_valid && !result_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", quiet_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	// row driver, fed from the backlog
	always @(negedge clk) begin
		grid_row_t item;
		logic      give;
		give = 1'b0;
		if (arst_n && (!row_valid || row_took)) begin
			if (row_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item = row_backlog.pop_front();
				give = 1'b1;
				row_cells <= item.cells;
				last_row <= item.last;
			end
			row_valid <= give;
		end
	end

	// receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		logic hold;
		if (hold_requests != holds_served) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			hold = 1'b1;
		end else begin
			hold = ($urandom_range(0, 99) < recv_stall_pct);
		end
		result_stall <= arst_n ? hold : 1'b0;
	end

	task automatic offer(lgre_pkg::lgre_row_t cells, logic last);
		grid_row_t item;
		item.cells = cells;
		item.last = last;
		row_backlog.push_back(item);
	endtask

	// wait until every row is in and every result is out
	task automatic settle();
		while (row_backlog.size() != 0 || row_valid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(lgre_pkg::lgre_width_t w);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_we <= 1'b0;
		grid_width = w;
		width_writes++;
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	function automatic lgre_pkg::lgre_row_t random_row();
		lgre_pkg::lgre_row_t r;
		case ($urandom_range(0, 9))
			0: r = '0;
			1: r = '1;
			5: r = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
			6: r = {$urandom, $urandom} | {$urandom, $urandom};
			7: r = lgre_pkg::lgre_row_t'($urandom_range(1, 7)) << $urandom_range(0, 61);
			8: r = {2'($urandom_range(0, 3)), 60'd0, 2'($urandom_range(0, 3))};
			default: r = {$urandom, $urandom};
		endcase
		return r;
	endfunction

	// one random row of the current grid; starts a new grid when needed
	task automatic queue_grid_row();
		int pick;
		if (grid_rows_left == 0) begin
			pick = $urandom_range(0, 9);
			if (pick == 0)
				grid_rows_left = 1;
			else if (pick <= 6)
				grid_rows_left = $urandom_range(2, 5);
			else if (pick <= 8)
				grid_rows_left = $urandom_range(6, 12);
			else
				grid_rows_left = $urandom_range(20, 40);
		end
		grid_rows_left--;
		offer(random_row(), grid_rows_left == 0);
	endtask

	initial begin
		lgre_pkg::lgre_width_t phase_widths[PHASE_COUNT];
		int                    mode;

		phase_widths = '{7'd64, 7'd0, 7'd1, 7'd2, 7'd3, 7'd127, 7'd65, 7'd63, 7'd32,
			7'd0, 7'd0, 7'd64};
		phase_widths[9] = lgre_pkg::lgre_width_t'($urandom_range(4, 62));
		phase_widths[10] = lgre_pkg::lgre_width_t'($urandom_range(0, 127));

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: reset width, single-row grids, blinker, edge columns
		offer('1, 1'b1);
		offer('0, 1'b1);
		offer(lgre_pkg::lgre_row_t'(1) << 10, 1'b0);
		offer(lgre_pkg::lgre_row_t'(1) << 10, 1'b0);
		offer(lgre_pkg::lgre_row_t'(1) << 10, 1'b1);
		offer({2'b11, 61'd0, 1'b1}, 1'b0);
		offer('1, 1'b0);
		offer({1'b1, 61'd0, 2'b11}, 1'b1);
		offer('1, 1'b0);
		offer('1, 1'b1);
		settle();
		// width zero kills everything
		set_width(7'd0);
		offer('1, 1'b0);
		offer('1, 1'b1);
		settle();
		// width above the column count behaves as full width
		set_width(7'd127);
		offer({$urandom, $urandom}, 1'b0);
		offer({$urandom, $urandom}, 1'b1);
		settle();
		set_width(7'd1);
		offer('1, 1'b0);
		offer('1, 1'b0);
		offer('1, 1'b1);
		settle();
		set_width(7'd3);
		offer('1, 1'b0);
		offer(64'h5, 1'b1);
		settle();
		// width changed while a grid is half in
		set_width(7'd64);
		offer('1, 1'b0);
		settle();
		set_width(7'd5);
		offer('1, 1'b0);
		offer('1, 1'b1);
		settle();

		// random phases; grids run across phase boundaries
		for (int p = 0; p < PHASE_COUNT; p++) begin
			set_width(phase_widths[p]);
			mode = p % 4;
			case (mode)
				0: set_idling(0, 0);
				1: set_idling(61, 0);
				2: set_idling(0, 61);
				default: set_idling(15, 15);
			endcase
			if (p == 4 || p == 8)
				hold_requests++;
			for (int i = 0; i < PHASE_ROWS; i++)
				queue_grid_row();
			if (p == PHASE_COUNT - 1) begin
				while (grid_rows_left != 0)
					queue_grid_row();
			end
			settle();
		end

		if (expected_rows.size() != 0)
			log_fault($sformatf("%0d result rows never arrived", expected_rows.size()));

		$display("Streamed %0d rows in %0d grids, checked %0d result rows, %0d width writes.",
			rows_sent, grids_sent, results_seen, width_writes);
		$display("Idle mixes: none, sender, receiver, both; %0d long receiver hold-offs.",
			holds_served);
		if (fault_count == 0) begin
			$display("PASS");
		end else begin
			$display("%0d failures", fault_count);
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+design
design/lgre_pkg.sv
design/lgre_cell.sv
design/lgre_out_fifo.sv
design/life_generation_row_engine.sv
sim/life_generation_row_engine_test.sv
